[hw/rtl/pse_pkg.sv]
// shared types and constants of the postfix stack evaluator
package pse_pkg;

	localparam int STACK_DEPTH = 32;
	localparam int VALUE_WIDTH = 32;

	localparam int SP_W = $clog2(STACK_DEPTH + 1);
	localparam int AW   = $clog2(STACK_DEPTH);

	// ascii codes
	localparam logic [7:0] SYM_ADD  = 8'd43;
	localparam logic [7:0] SYM_SUB  = 8'd45;
	localparam logic [7:0] SYM_MUL  = 8'd42;
	localparam logic [7:0] SYM_DIV  = 8'd47;
	localparam logic [7:0] SYM_ZERO = 8'd48;
	localparam logic [7:0] SYM_NINE = 8'd57;

	// result status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_UNDER = 2'd1;
	localparam logic [1:0] ST_DIVZ  = 2'd2;
	localparam logic [1:0] ST_OVER  = 2'd3;

	typedef enum logic [1:0] {
		OP_ADD,
		OP_SUB,
		OP_MUL,
		OP_DIV
	} alu_op_t;

	typedef struct packed {
		logic    start;
		alu_op_t op;
	} alu_req_t;

	typedef struct packed {
		logic done;
		logic divz;
	} alu_rsp_t;

endpackage

[hw/rtl/pse_ram.sv]
// generic single-port-write, single-port-read ram with registered read
module pse_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

[hw/rtl/pse_alu.sv]
// shared arithmetic unit: registered add, sub and mul, bit-serial signed divide
module pse_alu import pse_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  alu_req_t               req,
	input  logic [VALUE_WIDTH-1:0] a,
	input  logic [VALUE_WIDTH-1:0] b,
	output alu_rsp_t               rsp,
	output logic [VALUE_WIDTH-1:0] result
);

	localparam int W     = VALUE_WIDTH;
	localparam int CNT_W = $clog2(VALUE_WIDTH);

	typedef enum logic [1:0] {
		A_IDLE = 2'b01,
		A_DIV  = 2'b10
	} alu_state_t;

	alu_state_t       state_q;
	logic             done_q;
	logic             divz_q;
	logic [CNT_W-1:0] cnt_q;
	logic [W-1:0]     rem_q;
	logic [W-1:0]     quo_q;
	logic [W-1:0]     div_q;
	logic             neg_q;
	logic [W-1:0]     res_q;

	logic [W-1:0]   a_mag;
	logic [W-1:0]   b_mag;
	logic [2*W-1:0] prod;
	logic [W:0]     shifted;
	logic [W:0]     diff;
	logic           take;
	logic [W-1:0]   rem_next;
	logic [W-1:0]   quo_next;
	logic           start_div;

	assign a_mag     = a[W-1] ? (~a + 1'b1) : a;
	assign b_mag     = b[W-1] ? (~b + 1'b1) : b;
	assign prod      = a * b;
	assign shifted   = {rem_q, quo_q[W-1]};
	assign diff      = shifted - {1'b0, div_q};
	assign take      = ~diff[W];
	assign rem_next  = take ? diff[W-1:0] : shifted[W-1:0];
	assign quo_next  = {quo_q[W-2:0], take};
	assign start_div = (state_q == A_IDLE) && req.start && (req.op == OP_DIV) && (b != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= A_IDLE;
			done_q  <= 1'b0;
			divz_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			divz_q <= 1'b0;
			case (state_q)
				A_IDLE: begin
					if (req.start) begin
						if (start_div) begin
							state_q <= A_DIV;
							cnt_q   <= CNT_W'(W - 1);
						end else begin
							done_q <= 1'b1;
							divz_q <= (req.op == OP_DIV);
						end
					end
				end
				A_DIV: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						done_q  <= 1'b1;
						state_q <= A_IDLE;
					end
				end
				default: begin
					state_q <= A_IDLE;
				end
			endcase
		end
	end

	// datapath, no reset
	always_ff @(posedge clk) begin
		if (state_q == A_IDLE && req.start) begin
			case (req.op)
				OP_ADD:  res_q <= a + b;
				OP_SUB:  res_q <= a - b;
				OP_MUL:  res_q <= prod[W-1:0];
				default: res_q <= '0;
			endcase
			rem_q <= '0;
			quo_q <= a_mag;
			div_q <= b_mag;
			neg_q <= a[W-1] ^ b[W-1];
		end else if (state_q == A_DIV) begin
			rem_q <= rem_next;
			quo_q <= quo_next;
			if (cnt_q == '0) begin
				res_q <= neg_q ? (~quo_next + 1'b1) : quo_next;
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.divz = divz_q;
	assign result   = res_q;

endmodule

[hw/rtl/postfix_stack_evaluator.sv]
// top level of the postfix stack evaluator
//
// channel   dir  handshake            payload
// s_*       in   s_tvalid / s_tready  s_tdata[7:0] symbol, s_tlast last
// m_*       out  m_tvalid / m_tready  m_tdata[31:0] value, m_tuser[1:0] status
//
// a digit or an ignored character is taken without leaving S_IDLE; + - * go
// through S_RD_R, S_RD_L, S_CAP_L and S_EXEC (two stack reads from the ram, then
// the shared alu); / waits in S_EXEC on the alu divider, one quotient bit a cycle
// an item marked last adds S_POP and S_POPCAP, the final pop via the ram read port
// reset clears the stack pointer and the error; stack contents stay undefined
// the result waits in an output register; input is still taken meanwhile,
// but a final pop waits until that register has been taken
module postfix_stack_evaluator import pse_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] symbol
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] value
	output logic [1:0]  m_tuser    // [1:0] status
);

	localparam int W = VALUE_WIDTH;

	// sequencer states
	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_RD_R   = 7'b0000010,
		S_RD_L   = 7'b0000100,
		S_CAP_L  = 7'b0001000,
		S_EXEC   = 7'b0010000,
		S_POP    = 7'b0100000,
		S_POPCAP = 7'b1000000
	} state_t;

	state_t          state_q, state_d;
	logic [SP_W-1:0] sp_q, sp_d;
	logic [1:0]      err_q, err_d;
	logic            last_q;
	alu_op_t         op_q;
	logic            rzero_q;
	logic            lzero_q;
	logic [W-1:0]    right_q;
	logic            m_valid_q;
	logic [31:0]     m_value_q;
	logic [1:0]      m_status_q;

	logic            accept;
	logic            is_digit;
	logic            is_op;
	alu_op_t         sym_op;
	logic [W-1:0]    digit_val;
	logic            full;
	logic            empty;
	logic [SP_W-1:0] sp_m1;

	logic            wr_en;
	logic [AW-1:0]   wr_addr;
	logic [W-1:0]    wr_data;
	logic [AW-1:0]   rd_addr;
	logic [W-1:0]    rd_data;

	alu_req_t        alu_req;
	alu_rsp_t        alu_rsp;
	logic [W-1:0]    alu_a;
	logic [W-1:0]    alu_res;

	logic [64:0]     top_ext;
	logic            out_load;

	assign s_tready  = (state_q == S_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign is_digit  = s_tdata inside {[SYM_ZERO:SYM_NINE]};
	assign is_op     = s_tdata inside {SYM_ADD, SYM_SUB, SYM_MUL, SYM_DIV};
	assign digit_val = {{(W - 4){1'b0}}, s_tdata[3:0]};
	assign full      = (sp_q == SP_W'(STACK_DEPTH));
	assign empty     = (sp_q == '0);
	assign sp_m1     = sp_q - 1'b1;
	assign alu_a     = lzero_q ? '0 : rd_data;

	// sign-extend or truncate the popped top to the 32-bit result field
	assign top_ext = {{(65 - W){rd_data[W-1]}}, rd_data};

	always_comb begin
		case (s_tdata)
			SYM_ADD: sym_op = OP_ADD;
			SYM_SUB: sym_op = OP_SUB;
			SYM_MUL: sym_op = OP_MUL;
			default: sym_op = OP_DIV;
		endcase
	end

	always_comb begin
		state_d       = state_q;
		sp_d          = sp_q;
		err_d         = err_q;
		wr_en         = 1'b0;
		wr_addr       = sp_q[AW-1:0];
		wr_data       = digit_val;
		rd_addr       = sp_m1[AW-1:0];
		alu_req.start = 1'b0;
		alu_req.op    = op_q;
		out_load      = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (is_digit) begin
						if (full) begin
							// digit dropped on a full stack
							if (err_q == ST_OK) err_d = ST_OVER;
						end else begin
							wr_en = 1'b1;
							sp_d  = sp_q + 1'b1;
						end
					end
					if (is_op) begin
						state_d = S_RD_R;
					end else if (s_tlast) begin
						state_d = S_POP;
					end
				end
			end
			S_RD_R: begin
				// pop right operand
				if (empty) begin
					if (err_q == ST_OK) err_d = ST_UNDER;
				end else begin
					sp_d = sp_m1;
				end
				state_d = S_RD_L;
			end
			S_RD_L: begin
				// pop left operand
				if (empty) begin
					if (err_q == ST_OK) err_d = ST_UNDER;
				end else begin
					sp_d = sp_m1;
				end
				state_d = S_CAP_L;
			end
			S_CAP_L: begin
				alu_req.start = 1'b1;
				state_d       = S_EXEC;
			end
			S_EXEC: begin
				if (alu_rsp.done) begin
					if (alu_rsp.divz && err_d == ST_OK) err_d = ST_DIVZ;
					if (full) begin
						if (err_d == ST_OK) err_d = ST_OVER;
					end else begin
						wr_en   = 1'b1;
						wr_data = alu_res;
						sp_d    = sp_q + 1'b1;
					end
					state_d = last_q ? S_POP : S_IDLE;
				end
			end
			S_POP: begin
				if (!m_valid_q) begin
					if (empty) begin
						if (err_q == ST_OK) err_d = ST_UNDER;
					end
					state_d = S_POPCAP;
				end
			end
			S_POPCAP: begin
				out_load = 1'b1;
				sp_d     = '0;
				err_d    = ST_OK;
				state_d  = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			sp_q      <= '0;
			err_q     <= ST_OK;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			sp_q    <= sp_d;
			err_q   <= err_d;
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// item, operand and result holding registers
	always_ff @(posedge clk) begin
		if (accept) begin
			last_q <= s_tlast;
			op_q   <= sym_op;
		end
		if (state_q == S_RD_R) begin
			rzero_q <= empty;
		end
		if (state_q == S_RD_L) begin
			lzero_q <= empty;
			right_q <= rzero_q ? '0 : rd_data;
		end
		if (out_load) begin
			m_value_q  <= (err_q == ST_OK) ? top_ext[31:0] : 32'd0;
			m_status_q <= err_q;
		end
	end

	pse_ram #(
		.WIDTH(VALUE_WIDTH),
		.DEPTH(STACK_DEPTH)
	) u_stack (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	pse_alu u_alu (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (alu_req),
		.a     (alu_a),
		.b     (right_q),
		.rsp   (alu_rsp),
		.result(alu_res)
	);

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_value_q;
	assign m_tuser  = m_status_q;

endmodule

[tb/postfix_stack_evaluator_tb.sv]
// testbench of the postfix stack evaluator: directed and random expressions vs a predictor
module postfix_stack_evaluator_tb import pse_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_HALF       = 6;
	localparam int RESET_CYCLES   = 10;
	localparam int MAX_GAP        = 18;
	localparam int ITEM_TARGET    = 1500;
	// long receiver hold, well beyond the time the block needs to fill up
	localparam int HOLD_CYCLES    = 300;
	// a final pop after a division is the longest path
	localparam int SETTLE_CYCLES  = 60;
	// slowest legal stretch without a handshake is the receiver hold
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int PRINT_LIMIT    = 30;

	// characters the block ignores, used as filler and as the top of the code range
	localparam logic [7:0] SYM_SPACE   = 8'd32;
	localparam logic [7:0] SYM_HIGHEST = 8'hff;

	typedef struct packed {
		logic [7:0] sym;
		logic       last;
	} char_t;

	typedef struct packed {
		logic [31:0] value;
		logic [1:0]  status;
	} outcome_t;

	// predictor of the evaluator plus the queue of results still to come
	class postfix_scoreboard;
		logic [VALUE_WIDTH-1:0] operands [STACK_DEPTH];
		int unsigned            depth;
		logic [1:0]             err;
		outcome_t               awaited_results [$];
		int unsigned            failures;
		int unsigned            checked;
		int unsigned            status_seen [4];

		function new();
			depth    = 0;
			err      = ST_OK;
			failures = 0;
			checked  = 0;
		endfunction

		// the first error of an expression sticks until its result is out
		function void latch_error(logic [1:0] code);
			if (err == ST_OK)
				err = code;
		endfunction

		function logic [VALUE_WIDTH-1:0] pull();
			if (depth == 0) begin
				latch_error(ST_UNDER);
				return '0;
			end
			depth--;
			return operands[depth];
		endfunction

		// a push onto a full stack is dropped
		function void push(logic [VALUE_WIDTH-1:0] v);
			if (depth >= STACK_DEPTH) begin
				latch_error(ST_OVER);
				return;
			end
			operands[depth] = v;
			depth++;
		endfunction

		// signed division on magnitudes, truncating toward zero;
		// the most negative value over minus one wraps back onto itself
		function logic [VALUE_WIDTH-1:0] quotient(logic [VALUE_WIDTH-1:0] num,
		                                          logic [VALUE_WIDTH-1:0] den);
			logic [VALUE_WIDTH-1:0] mag_n, mag_d, q;
			if (den == '0) begin
				latch_error(ST_DIVZ);
				return '0;
			end
			mag_n = num[VALUE_WIDTH-1] ? -num : num;
			mag_d = den[VALUE_WIDTH-1] ? -den : den;
			q     = mag_n / mag_d;
			return (num[VALUE_WIDTH-1] ^ den[VALUE_WIDTH-1]) ? -q : q;
		endfunction

		function void evaluate_symbol(logic [7:0] sym, logic last);
			logic [VALUE_WIDTH-1:0] rhs, lhs, top;
			logic signed [63:0]     wide;
			outcome_t               res;
			if (sym >= SYM_ZERO && sym <= SYM_NINE)
				push(sym - SYM_ZERO);
			else if (sym == SYM_ADD || sym == SYM_SUB || sym == SYM_MUL || sym == SYM_DIV) begin
				rhs = pull();
				lhs = pull();
				case (sym)
					SYM_ADD: push(lhs + rhs);
					SYM_SUB: push(lhs - rhs);
					SYM_MUL: push(lhs * rhs);
					default: push(quotient(lhs, rhs));
				endcase
			end
			if (last) begin
				top        = pull();
				wide       = signed'(top);
				res.value  = (err == ST_OK) ? wide[31:0] : 32'd0;
				res.status = err;
				awaited_results.push_back(res);
				depth = 0;
				err   = ST_OK;
			end
		endfunction

		function int unsigned pending();
			return awaited_results.size();
		endfunction

		task report(string what);
			failures++;
			if (failures <= PRINT_LIMIT)
				$display("mismatch at %0t: %s", $time, what);
		endtask

		task check_result(logic [31:0] value, logic [1:0] status);
			outcome_t want;
			if (awaited_results.size() == 0) begin
				report($sformatf("unexpected result value %0d status %0d",
				                 $signed(value), status));
				return;
			end
			want = awaited_results.pop_front();
			checked++;
			status_seen[want.status]++;
			if (value !== want.value)
				report($sformatf("value %0d, expected %0d", $signed(value),
				                 $signed(want.value)));
			if (status !== want.status)
				report($sformatf("status %0d, expected %0d", status, want.status));
		endtask
	endclass

	logic        clk;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = 8'd0;   // [7:0] symbol
	logic        s_tlast  = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;           // [31:0] value
	logic [1:0]  m_tuser;           // [1:0] status

	postfix_scoreboard sb = new();

	// expression being built, one item per character
	char_t       expr_q [$];
	int unsigned counted;
	int unsigned expressions;
	int unsigned idle_cycles;
	bit          calm_tx;
	bit          calm_rx;
	bit          hold_results;

	postfix_stack_evaluator u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// idle time before an item or a result; calm stretches have none at all
	function automatic int unsigned draw_gap(bit calm);
		if (calm || $urandom_range(0, 3) == 0)
			return 0;
		return $urandom_range(0, MAX_GAP);
	endfunction

	function automatic void put(logic [7:0] sym);
		expr_q.push_back('{sym, 1'b0});
	endfunction

	function automatic void put_text(string s);
		for (int i = 0; i < s.len(); i++)
			put(s[i]);
	endfunction

	function automatic void close_expr();
		expr_q[expr_q.size() - 1].last = 1'b1;
	endfunction

	function automatic logic [7:0] random_digit();
		return SYM_ZERO + 8'($urandom_range(0, 9));
	endfunction

	function automatic logic [7:0] pick_operator();
		case ($urandom_range(0, 3))
			0:       return SYM_ADD;
			1:       return SYM_SUB;
			2:       return SYM_MUL;
			default: return SYM_DIV;
		endcase
	endfunction

	// valid postfix with random content; now and then a stray operator
	// or operands left below the top
	function automatic void gen_wellformed();
		int unsigned live, steps, cap;
		steps = $urandom_range(1, 14);
		cap   = $urandom_range(2, 8);
		live  = 0;
		repeat (steps) begin
			if ($urandom_range(0, 9) == 0)
				put(SYM_SPACE);
			if (live >= 2 && (live >= cap || $urandom_range(0, 1) == 1)) begin
				put(pick_operator());
				live--;
			end else begin
				put(random_digit());
				live++;
			end
		end
		case ($urandom_range(0, 9))
			0:       put(pick_operator());
			1:       ;
			default: while (live > 1) begin
				put(pick_operator());
				live--;
			end
		endcase
		close_expr();
	endfunction

	// repeated products that can wrap past 32 bits, now and then one more operation
	function automatic void gen_power();
		put(random_digit());
		repeat ($urandom_range(4, 14)) begin
			put(random_digit());
			put(SYM_MUL);
		end
		if ($urandom_range(0, 1) == 1) begin
			put(random_digit());
			put(pick_operator());
		end
		close_expr();
	endfunction

	// build the most negative value as 8^10 * 2, then push it over the edge
	function automatic void gen_most_negative();
		put_text("8");
		repeat (9)
			put_text("8*");
		put_text("2*");
		case ($urandom_range(0, 3))
			0:       put_text("01-/");   // over minus one wraps onto itself
			1:       put_text("1-");     // wraps to the most positive value
			2:       put_text("3/");
			default: put_text("01-*");
		endcase
		close_expr();
	endfunction

	// digits from just under to past the stack depth, then up to three operators
	function automatic void gen_overflow();
		repeat ($urandom_range(STACK_DEPTH - 2, STACK_DEPTH + 4))
			put(random_digit());
		repeat ($urandom_range(0, 3))
			put(pick_operator());
		close_expr();
	endfunction

	// arbitrary bytes, with last set at random inside and always at the end
	function automatic void gen_noise();
		repeat ($urandom_range(1, 8)) begin
			put(8'($urandom_range(0, 255)));
			if ($urandom_range(0, 3) == 0)
				close_expr();
		end
		close_expr();
	endfunction

	task automatic send_item(char_t c);
		int unsigned gap;
		gap = draw_gap(calm_tx);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= c.sym;
		s_tlast  <= c.last;
		do @(posedge clk); while (!s_tready);
		sb.evaluate_symbol(c.sym, c.last);
		// ignored characters do not count toward the item total unless marked last
		if (c.last || (c.sym >= SYM_ZERO && c.sym <= SYM_NINE) || c.sym == SYM_ADD
		    || c.sym == SYM_SUB || c.sym == SYM_MUL || c.sym == SYM_DIV)
			counted++;
	endtask

	task automatic send_expr();
		foreach (expr_q[i])
			send_item(expr_q[i]);
		expr_q.delete();
		expressions++;
	endtask

	// sender pause: s_tvalid drops and nothing new goes out until
	// every result has been taken
	task automatic drain_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	// result side: random stalls per result, plus one long hold on request
	initial begin : result_sink
		int unsigned wait_n;
		@(posedge arst_n);
		forever begin
			if (hold_results) begin
				hold_results = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			wait_n = draw_gap(calm_rx);
			if (wait_n != 0) begin
				m_tready <= 1'b0;
				repeat (wait_n) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata, m_tuser);
	end

	// watchdog on cycles with no handshake on either side
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles, %0d results outstanding",
			         WATCHDOG_LIMIT, sb.pending());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin : stimulus
		bit pressure_done;
		pressure_done = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: digit extremes, every operator, truncation toward zero,
		// divide by zero, missing operands, first error winning, final pop on
		// an empty stack with the highest code, leftovers below the top
		put_text("0");     close_expr(); send_expr();
		put_text("09-2/"); close_expr(); send_expr();
		put_text("34+");   close_expr(); send_expr();
		put_text("35-");   close_expr(); send_expr();
		put_text("78*");   close_expr(); send_expr();
		put_text("50/");   close_expr(); send_expr();
		put_text("+");     close_expr(); send_expr();
		put_text("+0/");   close_expr(); send_expr();
		put(SYM_HIGHEST);  close_expr(); send_expr();
		put_text("12");    close_expr(); send_expr();
		drain_results();

		// random: mostly valid expressions, the rest edge builders and noise
		while (counted < ITEM_TARGET) begin
			if (expressions % 40 == 0) begin
				calm_tx = ($urandom_range(0, 3) == 0);
				calm_rx = ($urandom_range(0, 3) == 0);
			end
			if (!pressure_done && counted > ITEM_TARGET / 3) begin
				// hold results back while items keep coming until input stalls
				pressure_done = 1'b1;
				hold_results  = 1'b1;
				calm_tx       = 1'b1;
				repeat (30) begin
					gen_wellformed();
					send_expr();
				end
				calm_tx = 1'b0;
				drain_results();
			end
			if ($urandom_range(0, 49) == 0)
				drain_results();
			case ($urandom_range(0, 99)) inside
				[0:59]:  gen_wellformed();
				[60:69]: gen_power();
				[70:73]: gen_most_negative();
				[74:79]: gen_overflow();
				default: gen_noise();
			endcase
			send_expr();
		end

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("ran %0d expressions, %0d counted items, %0d results checked",
		         expressions, counted, sb.checked);
		$display("statuses seen: ok %0d, underflow %0d, divide by zero %0d, overflow %0d",
		         sb.status_seen[ST_OK], sb.status_seen[ST_UNDER],
		         sb.status_seen[ST_DIVZ], sb.status_seen[ST_OVER]);
		if (sb.failures == 0 && sb.pending() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
